>>> rtl/mbrm_pkg.sv
// Shared types, constants and CRC function for the Modbus register read master.
package mbrm_pkg;

    localparam int BUFFER_BYTES  = 64;
    localparam int MAX_REGISTERS = 16;

    localparam int BUF_AW   = $clog2(BUFFER_BYTES);
    localparam int CNT_W    = 5;
    localparam int LEN_W    = 7;
    localparam int IDX_W    = 4;
    localparam int MAX_CNT_I = (MAX_REGISTERS < (BUFFER_BYTES - 5) / 2) ?
                               MAX_REGISTERS : (BUFFER_BYTES - 5) / 2;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CNT_I);

    localparam logic [7:0]  SLAVE_RESET   = 8'h01;
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_BYTE  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [1:0] KIND_TX   = 2'd0;
    localparam logic [1:0] KIND_REG  = 2'd1;
    localparam logic [1:0] KIND_STAT = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT = 2'd1;
    localparam logic [1:0] STAT_INVALID = 2'd2;

    localparam logic CFG_SLAVE   = 1'b0;
    localparam logic CFG_TIMEOUT = 1'b1;

    typedef struct packed {
        logic       start;
        logic       tx_load;
        logic       rx_write;
        logic       tick;
        logic       rd_issue;
        logic       word_load;
        logic       stat_load;
        logic [1:0] stat_code;
    } mbrm_cmd_t;

    typedef struct packed {
        logic tx_last;
        logic frame_done;
        logic timed_out;
        logic rx_none;
        logic crc_ok;
        logic cnt_zero;
        logic word_last;
    } mbrm_sts_t;

    // CRC-16/MODBUS, one byte, reflected poly 0xA001
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 16'hA001;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/mbrm_dp.sv
// Datapath: config registers, request builder, reply buffer, CRC check, output register.
module mbrm_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [15:0]            cfg_wdata,
    input  logic [7:0]             s_function_code,
    input  logic [15:0]            s_start_address,
    input  logic [4:0]             s_register_count,
    input  logic [7:0]             s_rx_byte,
    input  mbrm_pkg::mbrm_cmd_t    cmd,
    output mbrm_pkg::mbrm_sts_t    sts,
    output logic [1:0]             m_out_kind,
    output logic [7:0]             m_tx_byte,
    output logic [3:0]             m_reg_index,
    output logic [15:0]            m_reg_value,
    output logic [1:0]             m_status,
    output logic                   m_last
);

    logic [7:0]                      slave_reg;
    logic [15:0]                     timeout_reg;
    logic [mbrm_pkg::LEN_W-1:0]      br_reg;
    logic [mbrm_pkg::LEN_W-1:0]      exp_reg;
    logic [mbrm_pkg::CNT_W-1:0]      cnt_reg;
    logic [15:0]                     elapsed_reg;

    logic [7:0]                      fc_reg;
    logic [15:0]                     addr_reg;
    logic [15:0]                     crc_reg;
    logic [2:0]                      tx_idx_reg;
    logic [15:0]                     rx_crc_reg;
    logic [15:0]                     tail_reg;
    logic [mbrm_pkg::IDX_W-1:0]      ri_reg;
    logic [7:0]                      rd_hi_reg;
    logic [7:0]                      rd_lo_reg;

    logic [7:0] mem [mbrm_pkg::BUFFER_BYTES];

    logic [mbrm_pkg::CNT_W-1:0]      cnt_c;
    logic [7:0]                      tx_b;
    logic [15:0]                     el_inc;
    logic [mbrm_pkg::LEN_W-1:0]      br_p1;
    logic [mbrm_pkg::BUF_AW-1:0]     hi_a;
    logic [mbrm_pkg::BUF_AW-1:0]     lo_a;

    assign cnt_c = (s_register_count > mbrm_pkg::MAX_CNT) ? mbrm_pkg::MAX_CNT
                                                          : s_register_count;
    assign el_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign br_p1  = br_reg + mbrm_pkg::LEN_W'(1);
    assign hi_a   = mbrm_pkg::BUF_AW'(3) + mbrm_pkg::BUF_AW'({ri_reg, 1'b0});
    assign lo_a   = hi_a + mbrm_pkg::BUF_AW'(1);

    always_comb begin
        case (tx_idx_reg)
            3'd0:    tx_b = slave_reg;
            3'd1:    tx_b = fc_reg;
            3'd2:    tx_b = addr_reg[15:8];
            3'd3:    tx_b = addr_reg[7:0];
            3'd4:    tx_b = 8'h00;
            3'd5:    tx_b = 8'(cnt_reg);
            3'd6:    tx_b = crc_reg[7:0];
            default: tx_b = crc_reg[15:8];
        endcase
    end

    assign sts.tx_last    = (tx_idx_reg == 3'd7);
    assign sts.frame_done = (br_p1 >= exp_reg);
    assign sts.timed_out  = (el_inc >= timeout_reg);
    assign sts.rx_none    = (br_reg == '0);
    assign sts.crc_ok     = (tail_reg == rx_crc_reg);
    assign sts.cnt_zero   = (cnt_reg == '0);
    assign sts.word_last  = ({1'b0, ri_reg} + mbrm_pkg::CNT_W'(1) == cnt_reg);

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_reg   <= mbrm_pkg::SLAVE_RESET;
            timeout_reg <= mbrm_pkg::TIMEOUT_RESET;
            br_reg      <= '0;
            exp_reg     <= '0;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mbrm_pkg::CFG_SLAVE:   slave_reg   <= cfg_wdata[7:0];
                    mbrm_pkg::CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                    default:               slave_reg   <= slave_reg;
                endcase
            end
            if (cmd.start) begin
                cnt_reg     <= cnt_c;
                exp_reg     <= mbrm_pkg::LEN_W'(5) + mbrm_pkg::LEN_W'({cnt_c, 1'b0});
                br_reg      <= '0;
                elapsed_reg <= '0;
            end
            if (cmd.rx_write) begin
                br_reg <= br_p1;
            end
            if (cmd.tick) begin
                elapsed_reg <= el_inc;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            fc_reg     <= s_function_code;
            addr_reg   <= s_start_address;
            crc_reg    <= 16'hFFFF;
            tx_idx_reg <= '0;
            rx_crc_reg <= 16'hFFFF;
            ri_reg     <= '0;
        end
        if (cmd.tx_load) begin
            tx_idx_reg <= tx_idx_reg + 3'd1;
            if (tx_idx_reg < 3'd6) begin
                crc_reg <= mbrm_pkg::crc16_byte(crc_reg, tx_b);
            end
        end
        if (cmd.rx_write) begin
            mem[br_reg[mbrm_pkg::BUF_AW-1:0]] <= s_rx_byte;
            if (br_reg + mbrm_pkg::LEN_W'(2) < exp_reg) begin
                rx_crc_reg <= mbrm_pkg::crc16_byte(rx_crc_reg, s_rx_byte);
            end else begin
                tail_reg <= {s_rx_byte, tail_reg[15:8]};
            end
        end
        if (cmd.rd_issue) begin
            rd_hi_reg <= mem[hi_a];
            rd_lo_reg <= mem[lo_a];
        end
        if (cmd.tx_load) begin
            m_out_kind  <= mbrm_pkg::KIND_TX;
            m_tx_byte   <= tx_b;
            m_reg_index <= '0;
            m_reg_value <= '0;
            m_status    <= mbrm_pkg::STAT_OK;
            m_last      <= sts.tx_last;
        end else if (cmd.word_load) begin
            m_out_kind  <= mbrm_pkg::KIND_REG;
            m_tx_byte   <= '0;
            m_reg_index <= ri_reg;
            m_reg_value <= {rd_hi_reg, rd_lo_reg};
            m_status    <= mbrm_pkg::STAT_OK;
            m_last      <= sts.word_last;
            ri_reg      <= ri_reg + mbrm_pkg::IDX_W'(1);
        end else if (cmd.stat_load) begin
            m_out_kind  <= mbrm_pkg::KIND_STAT;
            m_tx_byte   <= '0;
            m_reg_index <= '0;
            m_reg_value <= '0;
            m_status    <= cmd.stat_code;
            m_last      <= 1'b1;
        end
    end

endmodule

>>> rtl/mbrm_ctrl.sv
// Controller: request sequencing, reply wait, check and result emission.
module mbrm_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic [1:0]             s_req_type,
    output logic                   s_ready,
    output logic                   m_valid,
    input  logic                   m_ready,
    input  mbrm_pkg::mbrm_sts_t    sts,
    output mbrm_pkg::mbrm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TX,
        S_WAIT,
        S_CHECK,
        S_RD,
        S_WORD,
        S_FIN
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       m_valid_reg, m_valid_next;
    logic       acc;
    logic       out_free;

    assign s_ready  = (state_reg == S_IDLE) || (state_reg == S_WAIT);
    assign m_valid  = m_valid_reg;
    assign acc      = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (acc && s_req_type == mbrm_pkg::REQ_START) begin
                    cmd.start  = 1'b1;
                    state_next = S_TX;
                end
            end
            S_TX: begin
                if (out_free) begin
                    cmd.tx_load = 1'b1;
                    if (sts.tx_last) begin
                        state_next = S_WAIT;
                    end
                end
            end
            S_WAIT: begin
                if (acc && s_req_type == mbrm_pkg::REQ_BYTE) begin
                    cmd.rx_write = 1'b1;
                    if (sts.frame_done) begin
                        state_next = S_CHECK;
                    end
                end else if (acc && s_req_type == mbrm_pkg::REQ_TICK) begin
                    cmd.tick = 1'b1;
                    if (sts.timed_out) begin
                        code_next  = sts.rx_none ? mbrm_pkg::STAT_TIMEOUT
                                                 : mbrm_pkg::STAT_INVALID;
                        state_next = S_FIN;
                    end
                end
            end
            S_CHECK: begin
                if (!sts.crc_ok) begin
                    code_next  = mbrm_pkg::STAT_INVALID;
                    state_next = S_FIN;
                end else if (sts.cnt_zero) begin
                    code_next  = mbrm_pkg::STAT_OK;
                    state_next = S_FIN;
                end else begin
                    state_next = S_RD;
                end
            end
            S_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = S_WORD;
            end
            S_WORD: begin
                if (out_free) begin
                    cmd.word_load = 1'b1;
                    state_next    = sts.word_last ? S_IDLE : S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    cmd.stat_load = 1'b1;
                    cmd.stat_code = code_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.tx_load || cmd.word_load || cmd.stat_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            code_reg    <= mbrm_pkg::STAT_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

>>> rtl/modbus_read_register_master_unit.sv
// Top level of the Modbus RTU register read master.
// Start request: 8 request bytes out, one per cycle unless the output stalls.
// Reply byte or tick: accepted while waiting for the reply. A completing byte leads to a CRC
// check, then register words (each a reply buffer read, then its output), or one status result.
// The next request waits in the CRC check and while any output is still being emitted.
// Reset (synchronous, active low): idle, slave address 1, timeout 1000 ticks.
module modbus_read_register_master_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_function_code,
    input  logic [15:0] s_start_address,
    input  logic [4:0]  s_register_count,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_out_kind,
    output logic [7:0]  m_tx_byte,
    output logic [3:0]  m_reg_index,
    output logic [15:0] m_reg_value,
    output logic [1:0]  m_status,
    output logic        m_last
);

    mbrm_pkg::mbrm_cmd_t cmd;
    mbrm_pkg::mbrm_sts_t sts;

    mbrm_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_function_code  (s_function_code),
        .s_start_address  (s_start_address),
        .s_register_count (s_register_count),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .sts              (sts),
        .m_out_kind       (m_out_kind),
        .m_tx_byte        (m_tx_byte),
        .m_reg_index      (m_reg_index),
        .m_reg_value      (m_reg_value),
        .m_status         (m_status),
        .m_last           (m_last)
    );

    mbrm_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_req_type (s_req_type),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    a_one_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.tx_load, cmd.word_load, cmd.stat_load}))
        else $error("more than one output load in a cycle");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.tx_load || cmd.word_load || cmd.stat_load) |-> (!m_valid || m_ready))
        else $error("output register overwritten before taken");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind == mbrm_pkg::KIND_STAT) |-> m_last)
        else $error("status result not marked last");

    a_word_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_kind == mbrm_pkg::KIND_REG) |-> (m_status == mbrm_pkg::STAT_OK))
        else $error("register word with non-ok status");

endmodule
